// ----- rtl/atrl_pkg.sv -----
// ============================================================================
// atrl_pkg - shared types, constants and helpers of the AT response recognizer
// Beat layouts, wait-mode and status codes, control-line token table and
// the small character-class functions used by the line scanner and top level.
// ============================================================================
package atrl_pkg;

    // Text store capacity; at most TEXT_CAPACITY-1 bytes are counted
    localparam int TEXT_CAPACITY = 256;
    localparam int CNT_W         = $clog2(TEXT_CAPACITY);

    typedef logic [CNT_W-1:0] t_count;

    // Input kind codes
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Status codes
    localparam logic [1:0] ST_PENDING = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_ERR     = 2'd2;

    typedef enum logic [1:0] {
        WM_ACK  = 2'd0,
        WM_SCAN = 2'd1,
        WM_LINK = 2'd2,
        WM_RSSI = 2'd3
    } t_wait_mode;

    // Line scanner phase
    typedef enum logic {
        PH_LEAD = 1'b0,     // skipping leading blanks / line breaks
        PH_BODY = 1'b1      // inside the trimmed line text
    } t_phase;

    // Percent-only tracking over all stored bytes
    typedef enum logic [1:0] {
        PCT_NONE = 2'd0,
        PCT_ONE  = 2'd1,
        PCT_FAIL = 2'd2
    } t_pct;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] status;
        logic       ok_seen;
        logic       err_seen;
        logic       link_ok_seen;
        logic       pair_err_seen;
        logic       scan_end_seen;
        logic       rssi_seen;
        logic       percent_only;
        logic [7:0] byte_count;
    } t_out_beat;

    typedef struct packed {
        logic ok;
        logic err;
        logic link_ok;
        logic pair_err;
        logic scan_end;
        logic rssi;
    } t_flags;

    // Line scanner to top level: control lines completed by this byte,
    // and whether the visible text holds a qualifying RSSI report line
    typedef struct packed {
        logic ok;
        logic err;
        logic link_ok;
        logic pair_err;
        logic scan_end;
        logic rssi_avail;
    } t_scan;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_T     = 8'h54;

    // Control-line tokens, right-justified byte strings
    localparam int TOK_N    = 5;
    localparam int TK_LINK  = 0;
    localparam int TK_PAIR  = 1;
    localparam int TK_SCAN  = 2;
    localparam int TK_OK    = 3;
    localparam int TK_ERR   = 4;
    localparam logic [63:0] TOK_TEXT [TOK_N] = '{"LINK OK", "PAIR ERR", "SCAN END", "OK", "ERR"};
    localparam int          TOK_LEN  [TOK_N] = '{7, 8, 8, 2, 3};

    // Line position saturates once past the longest token
    localparam logic [3:0] POS_MAX = 4'd8;

    localparam logic [31:0] RSSI_TEXT = "RSSI";
    localparam logic [2:0]  RSSI_LEN  = 3'd4;

    function automatic logic is_eol(input logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
    endfunction

    // Character p of token k; zero beyond the token end
    function automatic logic [7:0] tok_char(input int k, input logic [3:0] p);
        int base;
        base = 8 * (TOK_LEN[k] - 1 - int'(p));
        if (base < 0) begin
            return CH_NUL;
        end
        return TOK_TEXT[k][base +: 8];
    endfunction

    function automatic logic [7:0] rssi_char(input logic [2:0] p);
        logic [1:0] idx;
        idx = p[1:0];
        return RSSI_TEXT[8 * (3 - int'(idx)) +: 8];
    endfunction

    // Byte count as reported, saturated to 8 bits
    function automatic logic [7:0] sat_count(input t_count cnt);
        int v;
        v = int'(cnt);
        return (v > 255) ? 8'hFF : 8'(v);
    endfunction

endpackage

// ----- rtl/at_response_line_recognizer.sv -----
// ============================================================================
// at_response_line_recognizer - AT command response line recognizer
// Consumes response bytes one beat at a time, keeps sticky flags for the
// control lines and RSSI reports, and returns one status beat per input beat.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+----------------------
//   in       | sink      | i_in_valid / o_in_stall  | i_in_data  (t_in_beat)
//   out      | source    | o_out_valid / i_out_stall| o_out_data (t_out_beat)
//   cfg      | sink      | i_cfg_valid / o_cfg_ready| i_cfg_data (wait mode)
//
// One input beat per cycle unless stalled; its registered result beat appears
// in the cycle after acceptance. All matching is done by the per-line scanner
// between the input port and the output register, so no stage repeats.
// Synchronous active-low reset clears flags, counts and the wait mode.
// A stalled output holds its beat; the input is stalled only while the
// output register is full and stalled.
// ============================================================================
module at_response_line_recognizer
    import atrl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_beat   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_beat  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    t_wait_mode r_wait_mode, n_wait_mode;
    t_count     r_count, n_count;
    t_flags     r_flags, n_flags;
    t_pct       r_pct, n_pct;
    logic       r_term, n_term;
    logic       r_out_valid, n_out_valid;
    t_out_beat  r_out, n_out;

    logic       in_acc;
    logic       is_byte;
    logic       is_clear;
    logic       stored;
    logic       visible;
    logic       done;
    t_scan      scan;

    // Handshakes
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Byte classification
    assign is_byte  = in_acc && (i_in_data.kind == KIND_BYTE);
    assign is_clear = in_acc && (i_in_data.kind == KIND_CLEAR);
    assign stored   = is_byte && (r_count < t_count'(TEXT_CAPACITY - 1));
    assign visible  = stored && !r_term && (i_in_data.rx_byte != CH_NUL);

    atrl_line_scan u_line_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (is_clear),
        .i_char_valid (visible),
        .i_char       (i_in_data.rx_byte),
        .o_scan       (scan)
    );

    // Wait mode register
    always_comb begin
        n_wait_mode = r_wait_mode;
        if (i_cfg_valid && o_cfg_ready) n_wait_mode = t_wait_mode'(i_cfg_data);
    end

    // Count, terminator and sticky flags
    always_comb begin
        n_count = r_count;
        n_term  = r_term;
        n_flags = r_flags;
        if (is_clear) begin
            n_count = '0;
            n_term  = 1'b0;
            n_flags = '0;
        end else if (is_byte) begin
            if (stored) begin
                n_count = r_count + t_count'(1);
                if (i_in_data.rx_byte == CH_NUL) n_term = 1'b1;
            end
            n_flags.ok       = r_flags.ok       | scan.ok;
            n_flags.err      = r_flags.err      | scan.err | scan.pair_err;
            n_flags.link_ok  = r_flags.link_ok  | scan.link_ok;
            n_flags.pair_err = r_flags.pair_err | scan.pair_err;
            n_flags.scan_end = r_flags.scan_end | scan.scan_end;
            n_flags.rssi     = r_flags.rssi | ((r_wait_mode == WM_RSSI) && scan.rssi_avail);
        end
    end

    // Percent-only tracking over stored bytes
    always_comb begin
        n_pct = r_pct;
        if (is_clear) begin
            n_pct = PCT_NONE;
        end else if (stored && !is_eol(i_in_data.rx_byte)) begin
            if ((i_in_data.rx_byte == CH_PCT) && (r_pct == PCT_NONE)) n_pct = PCT_ONE;
            else n_pct = PCT_FAIL;
        end
    end

    // Completion by wait mode
    always_comb begin
        unique case (r_wait_mode)
            WM_ACK:  done = n_flags.ok || n_flags.err;
            WM_SCAN: done = n_flags.scan_end || n_flags.err;
            WM_LINK: done = n_flags.link_ok || n_flags.pair_err || n_flags.err;
            WM_RSSI: done = n_flags.rssi || n_flags.err;
            default: done = 1'b0;
        endcase
    end

    // Result beat
    always_comb begin
        n_out               = r_out;
        n_out_valid         = r_out_valid && i_out_stall;
        if (in_acc) begin
            n_out_valid         = 1'b1;
            n_out.status        = !done ? ST_PENDING : (n_flags.err ? ST_ERR : ST_OK);
            n_out.ok_seen       = n_flags.ok;
            n_out.err_seen      = n_flags.err;
            n_out.link_ok_seen  = n_flags.link_ok;
            n_out.pair_err_seen = n_flags.pair_err;
            n_out.scan_end_seen = n_flags.scan_end;
            n_out.rssi_seen     = n_flags.rssi;
            n_out.percent_only  = (n_pct == PCT_ONE);
            n_out.byte_count    = sat_count(n_count);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_mode <= WM_ACK;
            r_count     <= '0;
            r_term      <= 1'b0;
            r_flags     <= '0;
            r_pct       <= PCT_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_wait_mode <= n_wait_mode;
            r_count     <= n_count;
            r_term      <= n_term;
            r_flags     <= n_flags;
            r_pct       <= n_pct;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_clear |=> (o_out_data.byte_count == 8'd0) && (o_out_data.status == ST_PENDING))
        else $error("clear beat did not report an empty state");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(TEXT_CAPACITY - 1))
        else $error("stored count past capacity");

    a_pair_sets_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.pair_err |-> r_flags.err)
        else $error("pair error flag without error flag");

    a_rssi_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_flags.rssi) |-> ($past(r_wait_mode) == WM_RSSI))
        else $error("rssi flag set outside rssi wait mode");

    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted beat produced no result");

endmodule

// ----- rtl/atrl_line_scan.sv -----
// ============================================================================
// atrl_line_scan - per-line incremental matcher
// Follows the visible text one byte at a time: trims leading blanks, matches
// the control-line tokens against the line prefix and qualifies completed
// lines as RSSI reports (token or signed digit, plus an undotted number).
// ============================================================================
module atrl_line_scan
    import atrl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_clear,
    input  logic       i_char_valid,
    input  logic [7:0] i_char,
    output t_scan      o_scan
);

    t_phase             r_phase, n_phase;
    logic [3:0]         r_pos, n_pos;
    logic [TOK_N-1:0]   r_alive, n_alive;
    logic [2:0]         r_prog, n_prog;
    logic [7:0]         r_first, n_first;
    logic               r_sgn, n_sgn;
    logic               r_at, n_at;
    logic               r_ok_cand, n_ok_cand;
    logic               r_prev_digit, n_prev_digit;
    logic               r_num, n_num;
    logic               r_rssi_avail, n_rssi_avail;

    logic               body_char;
    logic               at_start;
    logic [3:0]         pos;
    logic [TOK_N-1:0]   alive;
    logic [TOK_N-1:0]   tok_done;
    logic [2:0]         prog;
    logic               prev_digit;
    logic               num;
    logic               line_done;
    logic               qualify;
    logic [7:0]         up_char;

    // Phase: next state
    always_comb begin
        n_phase = r_phase;
        if (i_clear) begin
            n_phase = PH_LEAD;
        end else if (i_char_valid) begin
            unique case (r_phase)
                PH_LEAD: begin
                    if (!is_eol(i_char) && !is_blank(i_char)) n_phase = PH_BODY;
                end
                PH_BODY: begin
                    if (is_eol(i_char)) n_phase = PH_LEAD;
                end
                default: n_phase = PH_LEAD;
            endcase
        end
    end

    // Line content tracking
    always_comb begin
        at_start   = (r_phase == PH_LEAD);
        body_char  = i_char_valid && !is_eol(i_char) && (!at_start || !is_blank(i_char));
        pos        = at_start ? 4'd0 : r_pos;
        alive      = at_start ? {TOK_N{1'b1}} : r_alive;
        prog       = at_start ? 3'd0 : r_prog;
        prev_digit = at_start ? 1'b0 : r_prev_digit;
        num        = at_start ? 1'b0 : r_num;
        up_char    = to_upper(i_char);

        n_pos        = r_pos;
        n_alive      = r_alive;
        n_prog       = r_prog;
        n_first      = r_first;
        n_sgn        = r_sgn;
        n_at         = r_at;
        n_ok_cand    = r_ok_cand;
        n_prev_digit = r_prev_digit;
        n_num        = r_num;
        tok_done     = '0;

        if (body_char) begin
            // token prefix match, one lane per token
            for (int k = 0; k < TOK_N; k++) begin
                n_alive[k]  = alive[k] && (int'(pos) < TOK_LEN[k]) &&
                              (tok_char(k, pos) == i_char);
                tok_done[k] = n_alive[k] && (int'(pos) == TOK_LEN[k] - 1);
            end
            n_pos = (pos == POS_MAX) ? pos : pos + 4'd1;

            // RSSI substring, case folded
            if (prog == RSSI_LEN) begin
                n_prog = prog;
            end else if (up_char == rssi_char(prog)) begin
                n_prog = prog + 3'd1;
            end else if (up_char == CH_R) begin
                n_prog = 3'd1;
            end else begin
                n_prog = 3'd0;
            end

            // first two characters: sign+digit, "AT", "OK"
            if (pos == 4'd0) begin
                n_first   = i_char;
                n_sgn     = 1'b0;
                n_at      = 1'b0;
                n_ok_cand = 1'b0;
            end else if (pos == 4'd1) begin
                n_sgn     = is_sign(r_first) && is_digit(i_char);
                n_at      = (r_first == CH_A) && (i_char == CH_T);
                n_ok_cand = (r_first == CH_O) && (i_char == CH_K);
            end else if (!is_blank(i_char)) begin
                n_ok_cand = 1'b0;
            end

            // digit run ended by anything but a dot
            n_num        = num || (prev_digit && !is_digit(i_char) && (i_char != CH_DOT));
            n_prev_digit = is_digit(i_char);
        end

        // completed line qualifies as an RSSI report
        line_done = i_char_valid && (r_phase == PH_BODY) && is_eol(i_char);
        qualify   = line_done && !r_ok_cand && !r_at &&
                    ((r_prog == RSSI_LEN) || r_sgn) && (r_num || r_prev_digit);
        n_rssi_avail = i_clear ? 1'b0 : (r_rssi_avail || qualify);
    end

    // Scan outputs
    always_comb begin
        o_scan.link_ok    = tok_done[TK_LINK];
        o_scan.pair_err   = tok_done[TK_PAIR];
        o_scan.scan_end   = tok_done[TK_SCAN];
        o_scan.ok         = tok_done[TK_OK];
        o_scan.err        = tok_done[TK_ERR];
        o_scan.rssi_avail = n_rssi_avail;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEAD;
            r_rssi_avail <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_rssi_avail <= n_rssi_avail;
        end
    end

    // Line context, reloaded at every line start
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_alive      <= n_alive;
        r_prog       <= n_prog;
        r_first      <= n_first;
        r_sgn        <= n_sgn;
        r_at         <= n_at;
        r_ok_cand    <= n_ok_cand;
        r_prev_digit <= n_prev_digit;
        r_num        <= n_num;
    end

endmodule

// ----- tb/sv/at_response_line_recognizer_tb.sv -----
// ============================================================================
// at_response_line_recognizer_tb - self-checking bench of the AT line recognizer
// A short table of directed beats, then phases of random response text
// (control lines, RSSI reports, noise, zero bytes, store overflow) under each
// wait mode. A scoreboard model recomputes every status beat, and each output
// beat is checked field by field. Both channels idle and stall at random.
// ============================================================================
module at_response_line_recognizer_tb;
    import atrl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BEATS    = 180;
    localparam int MAX_PRINTS     = 40;

    // Named expectations for the directed rows
    localparam t_out_beat W_CLEARED = '0;
    localparam t_out_beat W_PCT1 =
        '{status: ST_PENDING, percent_only: 1'b1, byte_count: 8'd1, default: '0};
    localparam t_out_beat W_PCT2 =
        '{status: ST_PENDING, percent_only: 1'b1, byte_count: 8'd2, default: '0};
    localparam t_out_beat W_PCT3 =
        '{status: ST_PENDING, percent_only: 1'b1, byte_count: 8'd3, default: '0};
    localparam t_out_beat W_TWO_PCT =
        '{status: ST_PENDING, byte_count: 8'd4, default: '0};
    localparam t_out_beat W_ERR_LINE =
        '{status: ST_ERR, err_seen: 1'b1, byte_count: 8'd3, default: '0};
    localparam t_out_beat W_OK_LINE =
        '{status: ST_OK, ok_seen: 1'b1, byte_count: 8'd3, default: '0};
    localparam t_out_beat W_HIDDEN_K =
        '{status: ST_PENDING, byte_count: 8'd3, default: '0};

    typedef struct packed {
        t_in_beat  beat;
        logic      typed;
        t_out_beat want;
    } t_dir_row;

    localparam int DIR_N = 24;
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        '{'{KIND_CLEAR, CH_NUL}, 1'b1, W_CLEARED},
        '{'{KIND_BYTE, CH_PCT}, 1'b1, W_PCT1},
        '{'{KIND_BYTE, CH_CR}, 1'b1, W_PCT2},
        '{'{KIND_BYTE, CH_LF}, 1'b1, W_PCT3},
        '{'{KIND_BYTE, CH_PCT}, 1'b1, W_TWO_PCT},
        '{'{KIND_CLEAR, 8'hFF}, 1'b1, W_CLEARED},
        '{'{KIND_BYTE, "E"}, 1'b0, W_CLEARED},
        '{'{KIND_BYTE, "R"}, 1'b0, W_CLEARED},
        '{'{KIND_BYTE, "R"}, 1'b1, W_ERR_LINE},
        '{'{KIND_BYTE, "="}, 1'b0, W_CLEARED},
        '{'{KIND_CLEAR, CH_NUL}, 1'b1, W_CLEARED},
        '{'{KIND_BYTE, CH_TAB}, 1'b0, W_CLEARED},
        '{'{KIND_BYTE, CH_O}, 1'b0, W_CLEARED},
        '{'{KIND_BYTE, CH_K}, 1'b1, W_OK_LINE},
        '{'{KIND_BYTE, CH_SP}, 1'b0, W_CLEARED},
        '{'{KIND_BYTE, CH_CR}, 1'b0, W_CLEARED},
        '{'{KIND_CLEAR, CH_NUL}, 1'b1, W_CLEARED},
        '{'{KIND_BYTE, CH_O}, 1'b0, W_CLEARED},
        '{'{KIND_BYTE, CH_NUL}, 1'b0, W_CLEARED},
        '{'{KIND_BYTE, CH_K}, 1'b1, W_HIDDEN_K},
        '{'{KIND_BYTE, 8'hFF}, 1'b0, W_CLEARED},
        '{'{KIND_BYTE, 8'h80}, 1'b0, W_CLEARED},
        '{'{KIND_BYTE, 8'h7F}, 1'b0, W_CLEARED},
        '{'{KIND_CLEAR, CH_NUL}, 1'b1, W_CLEARED}
    };

    // Response words the random lines are built from
    string line_words [26] = '{
        "OK", "ERR", "ERROR", "ERR:12", "ERR=3", "ERR,1", "ERR 7", "ERR\t9",
        "LINK OK", "PAIR ERR", "SCAN END", "+RSSI:-70", "RSSI=-55,1", "rssi 3.4",
        "-72", "+5", "-1.2", "AT+RSSI?", "OKAY", "LINK  OK", "OK OK", "+CMD:1.",
        "SCAN", "PAIR ERROR", "Dev 12 rSsI", "%"
    };

    t_wait_mode phase_mode [8] = '{
        WM_ACK, WM_SCAN, WM_LINK, WM_RSSI, WM_RSSI, WM_LINK, WM_SCAN, WM_ACK
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_beat   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_beat  o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_data;

    // Scoreboard model state
    logic [7:0] text_mem [TEXT_CAPACITY];
    int         n_stored  = 0;
    int         n_visible = 0;
    bit         nul_hit   = 1'b0;
    t_flags     seen      = '0;
    t_wait_mode mode_q    = WM_ACK;

    t_out_beat  expect_q [$];
    logic       row_typed = 1'b0;
    t_out_beat  row_want  = '0;

    int n_fail    = 0;
    int n_results = 0;
    int n_sent    = 0;
    int idle_cnt  = 0;
    int burst_left = 0;
    int stall_left = 0;
    int stall_style = 0;

    at_response_line_recognizer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- character classes ----------------
    function automatic bit eol_char(input logic [7:0] c);
        return c == CH_CR || c == CH_LF;
    endfunction

    function automatic bit blank_char(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB;
    endfunction

    function automatic bit digit_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit sign_char(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'h20 : c;
    endfunction

    // Trimmed line equal to tok, or tok plus a separator when loose_tail
    function automatic bit ctl_line_present(input string tok, input bit loose_tail);
        int i, s, e, k, tl;
        bit same;
        logic [7:0] c;
        tl = tok.len();
        i = 0;
        while (i < n_visible) begin
            s = i;
            while (s < n_visible && (eol_char(text_mem[s]) || blank_char(text_mem[s]))) s++;
            e = s;
            while (e < n_visible && !eol_char(text_mem[e])) e++;
            while (e > s && blank_char(text_mem[e-1])) e--;
            if (e - s >= tl) begin
                same = 1'b1;
                for (k = 0; k < tl; k++) begin
                    if (text_mem[s+k] != tok[k]) same = 1'b0;
                end
                if (same) begin
                    if (e - s == tl) return 1'b1;
                    c = text_mem[s+tl];
                    if (loose_tail && (blank_char(c) || c == ":" || c == "=" || c == ","))
                        return 1'b1;
                end
            end
            i = e;
            while (i < n_visible && eol_char(text_mem[i])) i++;
        end
        return 1'b0;
    endfunction

    // Some number in [lo, hi) that is not followed by a dot
    function automatic bit span_has_number(input int lo, input int hi);
        int i, j;
        bit dig;
        i = lo;
        while (i < hi) begin
            j = i;
            dig = 1'b0;
            if (sign_char(text_mem[j]) && j + 1 < hi) j++;
            while (j < hi && digit_char(text_mem[j])) begin
                dig = 1'b1;
                j++;
            end
            if (dig) begin
                if (j >= hi || text_mem[j] != CH_DOT) return 1'b1;
                i = j + 1;
            end else begin
                i++;
            end
        end
        return 1'b0;
    endfunction

    // A finished line carrying an RSSI token or a signed value, plus a number
    function automatic bit rssi_line_present();
        int i, s, raw, e, len, k;
        bit skip, tok, sgn;
        i = 0;
        while (i < n_visible) begin
            s = i;
            while (s < n_visible && (eol_char(text_mem[s]) || blank_char(text_mem[s]))) s++;
            raw = s;
            while (raw < n_visible && !eol_char(text_mem[raw])) raw++;
            if (raw >= n_visible) return 1'b0;
            e = raw;
            while (e > s && blank_char(text_mem[e-1])) e--;
            if (e > s) begin
                len = e - s;
                skip = (len == 2 && text_mem[s] == CH_O && text_mem[s+1] == CH_K) ||
                       (len >= 2 && text_mem[s] == CH_A && text_mem[s+1] == CH_T);
                if (!skip) begin
                    tok = 1'b0;
                    for (k = s; k + 4 <= e && !tok; k++) begin
                        if (fold_upper(text_mem[k]) == "R" && fold_upper(text_mem[k+1]) == "S" &&
                            fold_upper(text_mem[k+2]) == "S" && fold_upper(text_mem[k+3]) == "I")
                            tok = 1'b1;
                    end
                    sgn = sign_char(text_mem[s]) && s + 1 < e && digit_char(text_mem[s+1]);
                    if ((tok || sgn) && span_has_number(s, e)) return 1'b1;
                end
            end
            i = raw;
            while (i < n_visible && eol_char(text_mem[i])) i++;
        end
        return 1'b0;
    endfunction

    // Stored bytes are one percent sign and line breaks only
    function automatic bit percent_alone();
        int i;
        bit one;
        one = 1'b0;
        for (i = 0; i < n_stored; i++) begin
            if (eol_char(text_mem[i])) continue;
            if (text_mem[i] == CH_PCT && !one) begin
                one = 1'b1;
                continue;
            end
            return 1'b0;
        end
        return one;
    endfunction

    // Apply one input beat to the model and return the status beat it yields
    function automatic t_out_beat predict_status(input t_in_beat b);
        t_out_beat r;
        bit done;
        if (b.kind == KIND_CLEAR) begin
            n_stored  = 0;
            n_visible = 0;
            nul_hit   = 1'b0;
            seen      = '0;
        end else begin
            if (n_stored < TEXT_CAPACITY - 1) begin
                text_mem[n_stored] = b.rx_byte;
                n_stored++;
                if (!nul_hit) begin
                    if (b.rx_byte == CH_NUL) nul_hit = 1'b1;
                    else n_visible++;
                end
            end
            if (ctl_line_present("LINK OK", 1'b0)) seen.link_ok = 1'b1;
            if (ctl_line_present("PAIR ERR", 1'b0)) begin
                seen.pair_err = 1'b1;
                seen.err      = 1'b1;
            end
            if (ctl_line_present("SCAN END", 1'b0)) seen.scan_end = 1'b1;
            if (ctl_line_present("OK", 1'b0)) seen.ok = 1'b1;
            if (ctl_line_present("ERR", 1'b1)) seen.err = 1'b1;
            if (mode_q == WM_RSSI && rssi_line_present()) seen.rssi = 1'b1;
        end
        case (mode_q)
            WM_SCAN: done = seen.scan_end || seen.err;
            WM_LINK: done = seen.link_ok || seen.pair_err || seen.err;
            WM_RSSI: done = seen.rssi || seen.err;
            default: done = seen.ok || seen.err;
        endcase
        r.status        = done ? (seen.err ? ST_ERR : ST_OK) : ST_PENDING;
        r.ok_seen       = seen.ok;
        r.err_seen      = seen.err;
        r.link_ok_seen  = seen.link_ok;
        r.pair_err_seen = seen.pair_err;
        r.scan_end_seen = seen.scan_end;
        r.rssi_seen     = seen.rssi;
        r.percent_only  = percent_alone();
        r.byte_count    = (n_stored > 255) ? 8'hFF : 8'(n_stored);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        n_fail++;
        if (n_fail <= MAX_PRINTS) $display("mismatch at result %0d: %s", n_results, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // Scoreboard: model update on input beats and config writes, checks on output beats
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) mode_q = t_wait_mode'(i_cfg_data);
            if (i_in_valid && !o_in_stall) begin
                want = predict_status(i_in_data);
                expect_q.push_back(row_typed ? row_want : want);
            end
            if (o_out_valid && !i_out_stall) begin
                if (expect_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = expect_q.pop_front();
                    check_field("status", o_out_data.status, want.status);
                    check_field("ok_seen", o_out_data.ok_seen, want.ok_seen);
                    check_field("err_seen", o_out_data.err_seen, want.err_seen);
                    check_field("link_ok_seen", o_out_data.link_ok_seen, want.link_ok_seen);
                    check_field("pair_err_seen", o_out_data.pair_err_seen, want.pair_err_seen);
                    check_field("scan_end_seen", o_out_data.scan_end_seen, want.scan_end_seen);
                    check_field("rssi_seen", o_out_data.rssi_seen, want.rssi_seen);
                    check_field("percent_only", o_out_data.percent_only, want.percent_only);
                    check_field("byte_count", o_out_data.byte_count, want.byte_count);
                end
                n_results++;
            end
            // watchdog on cycles without any handshake
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && !o_in_stall) ||
                (o_out_valid && !i_out_stall)) begin
                idle_cnt = 0;
            end else begin
                idle_cnt++;
                if (idle_cnt >= WATCHDOG_LIMIT) begin
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    // Receiver stall: styles held for random stretches
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(8, 48);
        end
        stall_left--;
        case (stall_style)
            0:       i_out_stall = 1'b0;
            1:       i_out_stall = ($urandom_range(0, 7) == 0);
            2:       i_out_stall = ($urandom_range(0, 3) != 0);
            default: i_out_stall = (stall_left % 3 == 0);
        endcase
    end

    // Present one input beat in bursts with random gaps, wait for acceptance
    task automatic push_beat(input t_in_beat b, input logic typed, input t_out_beat want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = b;
        row_typed  = typed;
        row_want   = want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic send_byte(input logic [7:0] c);
        push_beat('{KIND_BYTE, c}, 1'b0, W_CLEARED);
    endtask

    // Clear beat; now and then followed by a lone percent line
    task automatic send_clear();
        push_beat('{KIND_CLEAR, 8'($urandom_range(0, 255))}, 1'b0, W_CLEARED);
        if ($urandom_range(0, 3) == 0) begin
            send_byte(CH_PCT);
            repeat ($urandom_range(0, 2)) send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
        end
    endtask

    // One response line: padded word, rare corruption or zero byte, optional terminator
    task automatic send_line();
        string w;
        logic [7:0] q [$];
        int k;
        w = line_words[$urandom_range(0, 25)];
        repeat ($urandom_range(0, 2)) q.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
        for (k = 0; k < w.len(); k++) q.push_back(w[k]);
        if ($urandom_range(0, 9) == 0) q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 39) == 0) q.insert($urandom_range(0, q.size()), CH_NUL);
        repeat ($urandom_range(0, 2)) q.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
        case ($urandom_range(0, 5))
            0: ;
            1: q.push_back(CH_CR);
            2: q.push_back(CH_LF);
            default: begin
                q.push_back(CH_CR);
                q.push_back(CH_LF);
            end
        endcase
        foreach (q[k]) send_byte(q[k]);
    endtask

    // Mode write only once the block has drained
    task automatic set_mode(input t_wait_mode m);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        int r, ph, goal, sel, clear_pct;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        set_mode(WM_ACK);
        for (r = 0; r < DIR_N; r++) push_beat(DIR_ROWS[r].beat, DIR_ROWS[r].typed, DIR_ROWS[r].want);

        // Random phases; odd phases rarely clear so the store overflows
        goal = n_sent;
        for (ph = 0; ph < 8; ph++) begin
            set_mode(phase_mode[ph]);
            goal += PHASE_BEATS;
            clear_pct = (ph % 2 == 1) ? 1 : 10;
            if ($urandom_range(0, 1) == 0) send_clear();
            while (n_sent < goal) begin
                sel = $urandom_range(0, 99);
                if (sel < clear_pct) send_clear();
                else if (sel < 82) send_line();
                else repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expect_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        if (expect_q.size() != 0) report_mismatch("expected results never arrived");
        if (n_fail == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
